// ===== hdl/cmps_pkg.sv =====
// Shared types and constants for the cylinder max path sum block.
// Used by every module under hdl except cmps_ram; depends on nothing.
package cmps_pkg;

    localparam int CELL_W      = 16;
    localparam int SUM_W       = 28;
    localparam int BEST_W      = 27;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 32;
    localparam int ROW_TOTAL_W = 13;
    localparam int COL_TOTAL_W = 7;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 13;

    localparam int MAX_COLUMNS_DEF = 64;
    localparam int MAX_ROWS_DEF    = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_TOTAL    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_TOTAL = 4'd1;

    localparam logic [ROW_TOTAL_W-1:0] ROW_TOTAL_RESET    = 13'd1;
    localparam logic [COL_TOTAL_W-1:0] COLUMN_TOTAL_RESET = 7'd2;

    // Position of one cell on the board.
    typedef struct packed {
        logic first_row;
        logic last_row;
        logic first_col;
        logic last_col;
    } tag_t;

endpackage

// ===== hdl/cylinder_max_path_sum.sv =====
// Cylinder max path sum: streams board cells in row-major order and returns
// the greatest last-row path sum with wraparound columns.
// Depends on cmps_pkg, cmps_seq, cmps_dp and cmps_ram.
//
// Usage:
//   Cells enter on the s_ channel, one 16-bit signed value per item, in
//   row-major order. After the final cell of a board one item leaves on the
//   m_ channel holding the greatest last-row sum, floored at zero; then the
//   next board starts. Board size is set on the cfg channel (register 0 is
//   the row count, register 1 the column count), written only while idle;
//   each such write restarts the board.
//   Throughput is one cell per cycle while the output is not stalled. The
//   previous row of sums sits in a RAM read one entry ahead of each cell;
//   the cell is registered, its sum computed in the next cycle and written
//   back, and the result reaches the output register as the final cell leaves.
//   If the receiver stalls, cells keep flowing until a second result is
//   due; that final cell is held and s_tready drops until m_tready is seen.
//   Reset (aresetn low, synchronous) restores a one-row, two-column board
//   and empties the pipeline; the RAM needs no clearing since every board
//   writes its first row before reading it.
module cylinder_max_path_sum #(
    parameter int MAX_COLUMNS = cmps_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = cmps_pkg::MAX_ROWS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cmps_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] cell_value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cmps_pkg::M_TDATA_W-1:0]    m_tdata,   // [26:0] best_sum, zero above
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cmps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cmps_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cmps_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS);

    logic                    accept, restart, s1_adv, s1_emit, s1_fire, fwd_next;
    logic [CW-1:0]           col, rd_addr;
    tag_t                    tag;
    logic                    s1_valid_reg;
    tag_t                    s1_tag_reg;
    logic [CW-1:0]           s1_col_reg;
    logic signed [CELL_W-1:0] s1_cell_reg;
    logic                    fwd_reg;
    logic signed [SUM_W-1:0] fwd_data_reg;
    logic signed [SUM_W-1:0] ram_rdata, rd_eff, sum;
    logic signed [SUM_W-1:0] cur_reg, saved_left_reg, saved_first_reg, last_sum_reg;
    logic [BEST_W-1:0]       running_best_reg, best_final;
    logic                    m_valid_reg;
    logic [BEST_W-1:0]       best_out_reg;
    logic                    sum_wins;

    assign cfg_ready = 1'b1;

    assign s1_emit  = s1_tag_reg.last_row && s1_tag_reg.last_col;
    assign s1_adv   = !(s1_emit && m_valid_reg && !m_tready);
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    cmps_seq #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .accept   (accept),
        .col      (col),
        .rd_addr  (rd_addr),
        .tag      (tag),
        .restart  (restart)
    );

    cmps_ram #(
        .WIDTH(SUM_W),
        .DEPTH(MAX_COLUMNS)
    ) u_row_ram (
        .aclk   (aclk),
        .wr_en  (s1_fire),
        .wr_addr(s1_col_reg),
        .wr_data(sum),
        .rd_en  (accept),
        .rd_addr(rd_addr),
        .rd_data(ram_rdata)
    );

    // A read that hits the entry written in the same cycle takes the new sum.
    assign fwd_next = s1_fire && (s1_col_reg == rd_addr);
    assign rd_eff   = fwd_reg ? fwd_data_reg : ram_rdata;

    cmps_dp u_dp (
        .cell_in    (s1_cell_reg),
        .tag        (s1_tag_reg),
        .cur        (cur_reg),
        .rd         (rd_eff),
        .saved_left (saved_left_reg),
        .saved_first(saved_first_reg),
        .last_sum   (last_sum_reg),
        .sum        (sum)
    );

    assign sum_wins   = s1_tag_reg.last_row && (sum > $signed({1'b0, running_best_reg}));
    assign best_final = sum_wins ? sum[BEST_W-1:0] : running_best_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_tag_reg   <= tag;
            s1_col_reg   <= col;
            s1_cell_reg  <= $signed(s_tdata[CELL_W-1:0]);
            fwd_data_reg <= sum;
        end
        if (s1_fire) begin
            cur_reg      <= rd_eff;
            last_sum_reg <= sum;
        end
        if (s1_fire && s1_emit) begin
            best_out_reg <= best_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            fwd_reg          <= 1'b0;
            m_valid_reg      <= 1'b0;
            running_best_reg <= '0;
            saved_left_reg   <= '0;
            saved_first_reg  <= '0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= fwd_next;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire && s1_emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (restart) begin
                running_best_reg <= '0;
                saved_left_reg   <= '0;
                saved_first_reg  <= '0;
            end else if (s1_fire) begin
                saved_left_reg <= cur_reg;
                if (s1_tag_reg.first_col) begin
                    saved_first_reg <= cur_reg;
                end
                running_best_reg <= s1_emit ? '0 : best_final;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - BEST_W){1'b0}}, best_out_reg};

endmodule

// ===== hdl/cmps_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module cmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/cmps_seq.sv =====
// Configuration registers and board position counters.
// Depends on cmps_pkg.
module cmps_seq #(
    parameter int MAX_COLUMNS = cmps_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = cmps_pkg::MAX_ROWS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [cmps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cmps_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              accept,
    output logic [$clog2(MAX_COLUMNS)-1:0]    col,
    output logic [$clog2(MAX_COLUMNS)-1:0]    rd_addr,
    output cmps_pkg::tag_t                    tag,
    output logic                              restart
);
    import cmps_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [ROW_TOTAL_W-1:0] row_total_reg;
    logic [COL_TOTAL_W-1:0] column_total_reg;
    logic [CW-1:0]          col_reg, col_next;
    logic [RW-1:0]          row_reg, row_next;
    logic [31:0]            last_row_w, last_col_w;
    logic [RW-1:0]          last_row_idx;
    logic [CW-1:0]          last_col_idx;

    // Clamp the register values to the supported board sizes.
    always_comb begin
        if (row_total_reg == '0) begin
            last_row_w = 32'd0;
        end else if (32'(row_total_reg) > 32'(MAX_ROWS)) begin
            last_row_w = 32'(MAX_ROWS) - 32'd1;
        end else begin
            last_row_w = 32'(row_total_reg) - 32'd1;
        end
        if (column_total_reg < COL_TOTAL_W'(2)) begin
            last_col_w = 32'd1;
        end else if (32'(column_total_reg) > 32'(MAX_COLUMNS)) begin
            last_col_w = 32'(MAX_COLUMNS) - 32'd1;
        end else begin
            last_col_w = 32'(column_total_reg) - 32'd1;
        end
    end

    assign last_row_idx = last_row_w[RW-1:0];
    assign last_col_idx = last_col_w[CW-1:0];

    assign restart = cfg_valid &&
                     (cfg_index == REG_ROW_TOTAL || cfg_index == REG_COLUMN_TOTAL);

    assign tag.first_row = (row_reg == '0);
    assign tag.last_row  = (row_reg == last_row_idx);
    assign tag.first_col = (col_reg == '0);
    assign tag.last_col  = (col_reg == last_col_idx);
    assign col           = col_reg;

    // The read fetches the entry the following cell needs as its own column;
    // after the last column that is column zero of the next row.
    assign rd_addr = tag.last_col ? '0 : col_reg + CW'(1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (tag.last_col) begin
                col_next = '0;
                row_next = tag.last_row ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_total_reg    <= ROW_TOTAL_RESET;
            column_total_reg <= COLUMN_TOTAL_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
        end else begin
            if (cfg_valid && cfg_index == REG_ROW_TOTAL) begin
                row_total_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_COLUMN_TOTAL) begin
                column_total_reg <= cfg_data[COL_TOTAL_W-1:0];
            end
            if (restart) begin
                col_reg <= '0;
                row_reg <= '0;
            end else begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

endmodule

// ===== hdl/cmps_dp.sv =====
// Path sum of one cell: three-way max over the previous row and one add; on the first row, the cell alone.
// Depends on cmps_pkg.
module cmps_dp (
    input  logic signed [cmps_pkg::CELL_W-1:0] cell_in,
    input  cmps_pkg::tag_t                     tag,
    input  logic signed [cmps_pkg::SUM_W-1:0]  cur,
    input  logic signed [cmps_pkg::SUM_W-1:0]  rd,
    input  logic signed [cmps_pkg::SUM_W-1:0]  saved_left,
    input  logic signed [cmps_pkg::SUM_W-1:0]  saved_first,
    input  logic signed [cmps_pkg::SUM_W-1:0]  last_sum,
    output logic signed [cmps_pkg::SUM_W-1:0]  sum
);
    import cmps_pkg::*;

    logic signed [SUM_W-1:0] left, right, best_lc, best3, cell_ext;

    assign cell_ext = SUM_W'(cell_in);

    // At column zero the left neighbor is the previous row's last sum, which
    // is the sum computed for the cell just before this one.
    assign left  = tag.first_col ? last_sum : saved_left;
    assign right = tag.last_col ? saved_first : rd;

    assign best_lc = (cur > left) ? cur : left;
    assign best3   = (right > best_lc) ? right : best_lc;
    assign sum     = tag.first_row ? cell_ext : cell_ext + best3;

endmodule

// ===== hdl/cmps_checker.sv =====
// Port-level checks for cylinder_max_path_sum, bound to the top level.
// Depends on cmps_pkg and cylinder_max_path_sum.
module cmps_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [cmps_pkg::M_TDATA_W-1:0]  m_tdata
);
    import cmps_pkg::*;

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The sum is zero-extended, so the padding above it stays zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:BEST_W] == '0)
        else $error("result padding not zero");

    // A new result only follows an accepted item, since the final cell passes
    // through the input register before it loads the output register.
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a final item");

endmodule

bind cylinder_max_path_sum cmps_checker u_cmps_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
